// ===== design/ssmg_pkg.sv =====
// Shared definitions for the sorted-set maximum-gap tracker.
// Holds operation and error codes, default sizes and the cell control struct.
// No dependencies.
package ssmg_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_VALUE_BITS = 32;

  localparam int ANSWER_W = 32;
  localparam int COUNT_W  = 7;
  localparam int ERROR_W  = 2;

  localparam logic OP_DELETE = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [ERROR_W-1:0] ERR_OK   = 2'd0;
  localparam logic [ERROR_W-1:0] ERR_MISS = 2'd1;
  localparam logic [ERROR_W-1:0] ERR_FULL = 2'd2;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic ins;
    logic leaf_en;
  } cell_ctrl_t;

endpackage

// ===== design/ssmg_cell.sv =====
// One slot of the sorted table: holds a value, compares it with the key,
// shifts with its neighbors and produces the gap and last-value tree leaves.
// Depends on ssmg_pkg.
module ssmg_cell #(
  parameter int VALUE_BITS = ssmg_pkg::DEF_VALUE_BITS,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  ssmg_pkg::cell_ctrl_t   ctrl,
  input  logic [VALUE_BITS-1:0]  key,
  input  logic [CNT_W-1:0]       count,
  input  logic [VALUE_BITS-1:0]  left_value,
  input  logic                   left_lt,
  input  logic [VALUE_BITS-1:0]  right_value,
  output logic [VALUE_BITS-1:0]  value,
  output logic                   lt,
  output logic                   eq,
  output logic [VALUE_BITS-1:0]  gap,
  output logic [VALUE_BITS-1:0]  last
);

  localparam logic FIRST = (INDEX == 0);

  logic                  valid;
  logic                  is_last;
  logic [VALUE_BITS-1:0] value_next;

  assign valid   = CNT_W'(INDEX) < count;
  assign is_last = CNT_W'(INDEX + 1) == count;

  // Cells left of the insert point keep their value; the cell at the point
  // takes the key and the rest take their left neighbor. A delete pulls
  // every cell from the point onward from its right neighbor.
  always_comb begin
    if (lt) begin
      value_next = value;
    end else if (ctrl.ins) begin
      value_next = left_lt ? key : left_value;
    end else begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt <= valid && (value < key);
      eq <= valid && (value == key);
    end
    if (ctrl.upd_en) begin
      value <= value_next;
    end
    if (ctrl.leaf_en) begin
      gap  <= (!FIRST && valid) ? value - left_value : '0;
      last <= is_last ? value : '0;
    end
  end

endmodule

// ===== design/ssmg_max_tree.sv =====
// Registered binary tree that finds the largest neighbor gap and gathers
// the value of the last held entry, one tree level per clock.
// Depends on ssmg_pkg only through the default value width.
module ssmg_max_tree #(
  parameter int VALUE_BITS = ssmg_pkg::DEF_VALUE_BITS,
  parameter int LEAVES     = 64
) (
  input  logic                  clk,
  input  logic [VALUE_BITS-1:0] gap_in  [LEAVES],
  input  logic [VALUE_BITS-1:0] last_in [LEAVES],
  output logic [VALUE_BITS-1:0] max_gap,
  output logic [VALUE_BITS-1:0] last
);

  logic [VALUE_BITS-1:0] node_gap  [1:LEAVES-1];
  logic [VALUE_BITS-1:0] node_last [1:LEAVES-1];

  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    logic [VALUE_BITS-1:0] gap_a, gap_b, last_a, last_b;
    if (2 * k >= LEAVES) begin : g_leaf
      assign gap_a  = gap_in[2*k-LEAVES];
      assign gap_b  = gap_in[2*k+1-LEAVES];
      assign last_a = last_in[2*k-LEAVES];
      assign last_b = last_in[2*k+1-LEAVES];
    end else begin : g_inner
      assign gap_a  = node_gap[2*k];
      assign gap_b  = node_gap[2*k+1];
      assign last_a = node_last[2*k];
      assign last_b = node_last[2*k+1];
    end
    // At most one leaf carries a nonzero last value, so an OR collects it.
    always_ff @(posedge clk) begin
      node_gap[k]  <= (gap_a > gap_b) ? gap_a : gap_b;
      node_last[k] <= last_a | last_b;
    end
  end

  assign max_gap = node_gap[1];
  assign last    = node_last[1];

endmodule

// ===== design/sorted_set_max_gap_tracker_top.sv =====
// Top level of the sorted-set maximum-gap tracker.
// Depends on ssmg_pkg, ssmg_cell and ssmg_max_tree.
//
// Usage:
//   A command (op, value) is transferred at a rising edge with start high
//   and busy low. op 1 inserts value, op 0 deletes it. The block then runs
//   a compare step across all cells, a shift step and a leaf step, passes
//   level by level through the registered gap tree and then forms the
//   result. The result (answer, entry_count, error) is shown for exactly
//   one cycle with done high; busy falls in that same cycle, so the next
//   command can be taken at the edge that ends it. No new command is taken
//   while busy, and the depth of the gap tree sets how long that lasts.
//   answer is the span of the set less its largest neighbor gap, or zero
//   while two values or fewer are held. error reports a duplicate insert or
//   absent delete, or an insert into a full table; the set is then unchanged.
//   The receiver cannot stall: each result must be taken when done is high.
//   A synchronous reset empties the set and returns the block to idle; the
//   table contents are not cleared, only the held count.
module sorted_set_max_gap_tracker_top #(
  parameter int CAPACITY   = ssmg_pkg::DEF_CAPACITY,
  parameter int VALUE_BITS = ssmg_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          op,
  input  logic [31:0]                   value,
  output logic                          busy,
  output logic                          done,
  output logic [ssmg_pkg::ANSWER_W-1:0] answer,
  output logic [ssmg_pkg::COUNT_W-1:0]  entry_count,
  output logic [ssmg_pkg::ERROR_W-1:0]  error
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = $clog2(CAPACITY);
  localparam int LEAVES = 2 ** LEVELS;
  localparam int TCW    = $clog2(LEVELS);
  localparam int IN_W   = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int ANS_XW = (VALUE_BITS > ssmg_pkg::ANSWER_W) ? VALUE_BITS : ssmg_pkg::ANSWER_W;
  localparam int CNT_XW = (CNT_W > ssmg_pkg::COUNT_W) ? CNT_W : ssmg_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_LEAF,
    S_TREE,
    S_FIN
  } state_t;

  state_t                       state;
  logic                         cmd_op;
  logic [VALUE_BITS-1:0]        cmd_value;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic [ssmg_pkg::ERROR_W-1:0] err;
  logic [ssmg_pkg::ERROR_W-1:0] err_next;
  logic [TCW-1:0]               tree_cnt;
  logic                         upd_ok;
  logic                         present;
  ssmg_pkg::cell_ctrl_t         ctrl;

  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic                  cell_lt    [CAPACITY];
  logic                  cell_eq    [CAPACITY];
  logic [CAPACITY-1:0]   eq_vec;
  logic [VALUE_BITS-1:0] leaf_gap   [LEAVES];
  logic [VALUE_BITS-1:0] leaf_last  [LEAVES];
  logic [VALUE_BITS-1:0] root_gap;
  logic [VALUE_BITS-1:0] root_last;

  logic [IN_W-1:0]                 value_ext;
  logic [VALUE_BITS-1:0]           span_less;
  logic [ANS_XW-1:0]               span_ext;
  logic [CNT_XW-1:0]               count_ext;
  logic [ssmg_pkg::ANSWER_W-1:0]   answer_next;

  assign busy      = (state != S_IDLE);
  assign value_ext = IN_W'(value);

  // Table cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] lv, rv;
    logic                  llt;
    if (i == 0) begin : g_first
      assign lv  = cmd_value;
      assign llt = 1'b1;
    end else begin : g_mid
      assign lv  = cell_value[i-1];
      assign llt = cell_lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign rv = cell_value[i];
    end else begin : g_inner
      assign rv = cell_value[i+1];
    end
    ssmg_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (cmd_value),
      .count       (count),
      .left_value  (lv),
      .left_lt     (llt),
      .right_value (rv),
      .value       (cell_value[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i]),
      .gap         (leaf_gap[i]),
      .last        (leaf_last[i])
    );
    assign eq_vec[i] = cell_eq[i];
  end

  for (genvar j = CAPACITY; j < LEAVES; j++) begin : g_pad
    assign leaf_gap[j]  = '0;
    assign leaf_last[j] = '0;
  end

  ssmg_max_tree #(
    .VALUE_BITS (VALUE_BITS),
    .LEAVES     (LEAVES)
  ) u_tree (
    .clk     (clk),
    .gap_in  (leaf_gap),
    .last_in (leaf_last),
    .max_gap (root_gap),
    .last    (root_last)
  );

  // Decide the update from the registered match flags.
  always_comb begin
    present    = |eq_vec;
    upd_ok     = 1'b0;
    err_next   = ssmg_pkg::ERR_OK;
    count_next = count;
    if (cmd_op == ssmg_pkg::OP_INSERT) begin
      if (present) begin
        err_next = ssmg_pkg::ERR_MISS;
      end else if (count == CNT_W'(CAPACITY)) begin
        err_next = ssmg_pkg::ERR_FULL;
      end else begin
        upd_ok     = 1'b1;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (!present) begin
        err_next = ssmg_pkg::ERR_MISS;
      end else begin
        upd_ok     = 1'b1;
        count_next = count - CNT_W'(1);
      end
    end
  end

  always_comb begin
    ctrl.cmp_en  = (state == S_CMP);
    ctrl.upd_en  = (state == S_UPD) && upd_ok;
    ctrl.ins     = cmd_op;
    ctrl.leaf_en = (state == S_LEAF);
  end

  always_comb begin
    span_less   = root_last - cell_value[0] - root_gap;
    span_ext    = ANS_XW'(span_less);
    answer_next = (count <= CNT_W'(2)) ? '0 : span_ext[ssmg_pkg::ANSWER_W-1:0];
    count_ext   = CNT_XW'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_op    <= op;
            cmd_value <= value_ext[VALUE_BITS-1:0];
            state     <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          count <= count_next;
          err   <= err_next;
          state <= S_LEAF;
        end
        S_LEAF: begin
          tree_cnt <= TCW'(LEVELS - 1);
          state    <= S_TREE;
        end
        S_TREE: begin
          if (tree_cnt == '0) begin
            state <= S_FIN;
          end else begin
            tree_cnt <= tree_cnt - TCW'(1);
          end
        end
        S_FIN: begin
          answer      <= answer_next;
          entry_count <= count_ext[ssmg_pkg::COUNT_W-1:0];
          error       <= err;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIN))
    else $error("result strobe without a finished item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_count_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (state != S_UPD) |=> $stable(count))
    else $error("held count changed outside the update cycle");

  a_full_error_count: assert property (@(posedge clk) disable iff (rst)
    (done && error == ssmg_pkg::ERR_FULL) |-> (count == CNT_W'(CAPACITY)))
    else $error("full error reported while table not full");

  a_idle_when_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("block busy while showing a result");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for sorted_set_max_gap_tracker_top.
// Drives insert/delete commands, predicts every report from its own sorted table
// and checks it. Depends on ssmg_pkg and the tracker RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int SET_CAP      = ssmg_pkg::DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic        op;
    logic [31:0] value;
    bit          wait_drain;
  } command_t;

  typedef struct {
    logic [ssmg_pkg::ANSWER_W-1:0] answer;
    logic [ssmg_pkg::COUNT_W-1:0]  entry_count;
    logic [ssmg_pkg::ERROR_W-1:0]  error;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        op = ssmg_pkg::OP_DELETE;
  logic [31:0] value = '0;
  logic        busy;
  logic        done;
  logic [ssmg_pkg::ANSWER_W-1:0] answer;
  logic [ssmg_pkg::COUNT_W-1:0]  entry_count;
  logic [ssmg_pkg::ERROR_W-1:0]  error;

  command_t pending_cmds[$];
  report_t  expected_reports[$];

  // Predicted contents of the set, kept in ascending order.
  logic [31:0] tracked_vals [SET_CAP];
  int          tracked_count = 0;

  // Shadow of the set used only to steer stimulus generation.
  logic [31:0] gen_set[$];

  int total_items = 0;
  int accepted = 0;
  int fail_count = 0;
  int cycles = 0;

  sorted_set_max_gap_tracker_top u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .op(op),
    .value(value),
    .busy(busy),
    .done(done),
    .answer(answer),
    .entry_count(entry_count),
    .error(error)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic report_t apply_command(input logic cmd_op, input logic [31:0] v);
    report_t     r;
    int          pos;
    bit          present;
    logic [31:0] max_gap;
    logic [31:0] gap;
    pos = 0;
    while (pos < tracked_count && tracked_vals[pos] < v) pos++;
    present = (pos < tracked_count) && (tracked_vals[pos] == v);
    r.error = ssmg_pkg::ERR_OK;
    if (cmd_op == ssmg_pkg::OP_INSERT) begin
      // A duplicate is reported even when the table is full.
      if (present) begin
        r.error = ssmg_pkg::ERR_MISS;
      end else if (tracked_count >= SET_CAP) begin
        r.error = ssmg_pkg::ERR_FULL;
      end else begin
        for (int i = tracked_count; i > pos; i--) tracked_vals[i] = tracked_vals[i-1];
        tracked_vals[pos] = v;
        tracked_count++;
      end
    end else begin
      if (!present) begin
        r.error = ssmg_pkg::ERR_MISS;
      end else begin
        for (int i = pos; i + 1 < tracked_count; i++) tracked_vals[i] = tracked_vals[i+1];
        tracked_count--;
      end
    end
    r.answer = '0;
    if (tracked_count > 2) begin
      max_gap = '0;
      for (int i = 1; i < tracked_count; i++) begin
        gap = tracked_vals[i] - tracked_vals[i-1];
        if (gap > max_gap) max_gap = gap;
      end
      r.answer = tracked_vals[tracked_count-1] - tracked_vals[0] - max_gap;
    end
    r.entry_count = tracked_count[ssmg_pkg::COUNT_W-1:0];
    return r;
  endfunction

  function automatic int gen_find(input logic [31:0] v);
    for (int i = 0; i < gen_set.size(); i++) begin
      if (gen_set[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic void gen_push(input logic cmd_op, input logic [31:0] v, input bit drain);
    command_t c;
    int       idx;
    c.op = cmd_op;
    c.value = v;
    c.wait_drain = drain;
    pending_cmds.push_back(c);
    total_items++;
    idx = gen_find(v);
    if (cmd_op == ssmg_pkg::OP_INSERT && idx < 0 && gen_set.size() < SET_CAP)
      gen_set.push_back(v);
    if (cmd_op == ssmg_pkg::OP_DELETE && idx >= 0) gen_set.delete(idx);
  endfunction

  // Values crowd the ends of the range and a middle cluster so that duplicates,
  // hits on delete and wide spans all come up often.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($urandom_range(0, 63));
      2:       return 32'hFFFF_FFC0 + 32'($urandom_range(0, 63));
      default: return 32'h8000_0000 - 32'd32 + 32'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic int idle_pct();
    if (accepted < total_items / 3) return 28;
    if (accepted < (2 * total_items) / 3) return 48;
    return 0;
  endfunction

  initial begin : stimulus
    int  base;
    bit  first;
    // Directed part: empty set, value extremes, duplicate inserts and absent deletes, small sets.
    gen_push(ssmg_pkg::OP_DELETE, 32'd5, 1'b0);
    gen_push(ssmg_pkg::OP_INSERT, 32'h0000_0000, 1'b0);
    gen_push(ssmg_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0);
    gen_push(ssmg_pkg::OP_INSERT, 32'h0000_0000, 1'b0);
    gen_push(ssmg_pkg::OP_INSERT, 32'h8000_0000, 1'b0);
    gen_push(ssmg_pkg::OP_INSERT, 32'h0000_0001, 1'b0);
    gen_push(ssmg_pkg::OP_DELETE, 32'h0000_0002, 1'b0);
    gen_push(ssmg_pkg::OP_DELETE, 32'hFFFF_FFFF, 1'b0);
    gen_push(ssmg_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0);
    gen_push(ssmg_pkg::OP_INSERT, 32'h5555_5555, 1'b0);
    gen_push(ssmg_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0);
    gen_push(ssmg_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0);
    gen_push(ssmg_pkg::OP_DELETE, 32'h0000_0000, 1'b0);
    gen_push(ssmg_pkg::OP_DELETE, 32'h0000_0001, 1'b0);
    gen_push(ssmg_pkg::OP_DELETE, 32'h8000_0000, 1'b0);
    gen_push(ssmg_pkg::OP_DELETE, 32'h7FFF_FFFF, 1'b0);
    gen_push(ssmg_pkg::OP_DELETE, 32'h5555_5555, 1'b0);
    gen_push(ssmg_pkg::OP_DELETE, 32'hAAAA_AAAA, 1'b0);
    gen_push(ssmg_pkg::OP_DELETE, 32'h0000_0000, 1'b0);

    base = total_items;
    first = 1'b1;
    while (total_items - base < RANDOM_ITEMS) begin
      int kind;
      kind = first ? 0 : $urandom_range(0, 9);
      if (kind <= 2) begin
        // Fill to capacity, then push against the full table.
        while (gen_set.size() < SET_CAP) begin
          if (gen_set.size() != 0 && $urandom_range(0, 9) == 0)
            gen_push(ssmg_pkg::OP_INSERT, gen_set[$urandom_range(0, gen_set.size() - 1)],
                     first);
          else
            gen_push(ssmg_pkg::OP_INSERT, pick_value(), first);
          first = 1'b0;
        end
        repeat ($urandom_range(2, 4)) gen_push(ssmg_pkg::OP_INSERT, pick_value(), 1'b0);
        gen_push(ssmg_pkg::OP_INSERT, gen_set[$urandom_range(0, SET_CAP - 1)], 1'b0);
      end else if (kind <= 5) begin
        repeat ($urandom_range(20, 40)) begin
          int r;
          r = $urandom_range(0, 9);
          if (r < 4 && gen_set.size() != 0)
            gen_push(ssmg_pkg::OP_DELETE, gen_set[$urandom_range(0, gen_set.size() - 1)],
                     1'b0);
          else if (r == 4)
            gen_push(ssmg_pkg::OP_DELETE, pick_value(), 1'b0);
          else if (r == 5 && gen_set.size() != 0)
            gen_push(ssmg_pkg::OP_INSERT, gen_set[$urandom_range(0, gen_set.size() - 1)],
                     1'b0);
          else
            gen_push(ssmg_pkg::OP_INSERT, pick_value(), 1'b0);
        end
      end else if (kind == 6) begin
        // Empty the set completely, letting all reports drain before each of those deletes.
        while (gen_set.size() != 0)
          gen_push(ssmg_pkg::OP_DELETE, gen_set[$urandom_range(0, gen_set.size() - 1)],
                   first || kind == 6);
        gen_push(ssmg_pkg::OP_DELETE, pick_value(), 1'b0);
      end else begin
        repeat ($urandom_range(5, 15)) gen_push(1'($urandom_range(0, 1)), pick_value(), 1'b0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start || expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Driver: a transfer happens at an edge with start high and busy low.
  always @(posedge clk) begin : driver
    bit       take;
    command_t nxt;
    take = 1'b0;
    if (rst) begin
      start <= 1'b0;
      tracked_count = 0;
    end else begin
      if (start && !busy) begin
        expected_reports.push_back(apply_command(op, value));
        accepted++;
      end
      if (!(start && busy)) begin
        take = pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct();
        if (take && pending_cmds[0].wait_drain && expected_reports.size() != 0) take = 1'b0;
        if (take) begin
          nxt = pending_cmds.pop_front();
          start <= 1'b1;
          op <= nxt.op;
          value <= nxt.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each report is valid for the single cycle that done is high.
  always @(posedge clk) begin : monitor
    report_t want;
    if (!rst && done) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report: answer %0d entry_count %0d error %0d",
               answer, entry_count, error);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        if (answer !== want.answer) begin
          $error("answer: expected %0d, actual %0d", want.answer, answer);
          fail_count++;
        end
        if (entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
          fail_count++;
        end
        if (error !== want.error) begin
          $error("error: expected %0d, actual %0d", want.error, error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
design/ssmg_pkg.sv
design/ssmg_cell.sv
design/ssmg_max_tree.sv
design/sorted_set_max_gap_tracker_top.sv
tb/testbench.sv
